// File: design/bcmpd_pkg.sv
package bcmpd_pkg;

   localparam int LINE_MAX_DEFAULT = 20;

   localparam logic [11:0] STOP_PULSE_RESET = 12'd1500;
   localparam logic [11:0] PULSE_MAX_RESET  = 12'd1950;
   localparam logic [11:0] PULSE_MIN_RESET  = 12'd1050;
   localparam logic [7:0]  POWER_STEP_RESET = 8'd25;
   localparam logic [9:0]  POWER_MIN_RESET  = 10'd80;
   localparam logic [9:0]  POWER_MAX_RESET  = 10'd430;
   localparam logic [9:0]  START_POWER      = 10'd250;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_VT    = 8'h0b;
   localparam logic [7:0] CH_FF    = 8'h0c;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_QUEST = 8'h3f;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5a;
   localparam logic [7:0] CH_UP_D  = 8'h44;
   localparam logic [7:0] CH_UP_S  = 8'h53;
   localparam logic [7:0] CH_UP_W  = 8'h57;
   localparam logic [7:0] CH_UP_X  = 8'h58;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_H     = 8'h68;
   localparam logic [7:0] CH_L     = 8'h6c;
   localparam logic [7:0] CH_M     = 8'h6d;
   localparam logic [7:0] CH_N     = 8'h6e;
   localparam logic [7:0] CH_O     = 8'h6f;
   localparam logic [7:0] CH_P     = 8'h70;
   localparam logic [7:0] CH_S     = 8'h73;
   localparam logic [7:0] CH_W     = 8'h77;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CASE_OFFSET = 8'd32;

   typedef struct packed {
      logic [11:0] stop_pulse_us;
      logic [11:0] pulse_max_us;
      logic [11:0] pulse_min_us;
      logic [7:0]  power_step;
      logic [9:0]  power_min;
      logic [9:0]  power_max;
      logic        invert_left;
      logic        invert_right;
   } cfg_type;

   typedef struct packed {
      logic active;
      logic left_neg;
      logic right_neg;
   } drive_cmd_type;

   typedef enum logic [3:0] {
      CSR_STOP_PULSE   = 4'd0,
      CSR_PULSE_MAX    = 4'd1,
      CSR_PULSE_MIN    = 4'd2,
      CSR_POWER_STEP   = 4'd3,
      CSR_POWER_MIN    = 4'd4,
      CSR_POWER_MAX    = 4'd5,
      CSR_INVERT_LEFT  = 4'd6,
      CSR_INVERT_RIGHT = 4'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      REPLY_NONE    = 4'd0,
      REPLY_FWD     = 4'd1,
      REPLY_REV     = 4'd2,
      REPLY_LEFT    = 4'd3,
      REPLY_RIGHT   = 4'd4,
      REPLY_STOP    = 4'd5,
      REPLY_SPEED   = 4'd6,
      REPLY_ON      = 4'd7,
      REPLY_OFF     = 4'd8,
      REPLY_HELP    = 4'd9,
      REPLY_UNKNOWN = 4'd10
   } reply_type;

   typedef enum logic [2:0] {
      MATCH_EMPTY,
      MATCH_MON,
      MATCH_MOFF,
      MATCH_HELP,
      MATCH_UNKNOWN
   } match_type;

   typedef enum logic [3:0] {
      KEY_LINE_END,
      KEY_FWD,
      KEY_REV,
      KEY_LEFT,
      KEY_RIGHT,
      KEY_STOP,
      KEY_PLUS,
      KEY_MINUS,
      KEY_TEXT
   } key_type;

   typedef enum logic [1:0] {
      CTRL_IDLE,
      CTRL_SCAN,
      CTRL_RESULT
   } ctrl_state_type;

   typedef enum logic {
      SCAN_IDLE,
      SCAN_RUN
   } scan_state_type;

   function automatic logic is_trim(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
             (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      if ((c >= CH_UP_A) && (c <= CH_UP_Z)) begin
         return c + CASE_OFFSET;
      end
      return c;
   endfunction

   function automatic key_type classify_key(input logic [7:0] c);
      key_type k;
      unique case (c)
         CH_CR, CH_LF:             k = KEY_LINE_END;
         CH_W, CH_UP_W:            k = KEY_FWD;
         CH_S, CH_UP_S:            k = KEY_REV;
         CH_A, CH_UP_A:            k = KEY_LEFT;
         CH_D, CH_UP_D:            k = KEY_RIGHT;
         CH_X, CH_UP_X, CH_SPACE:  k = KEY_STOP;
         CH_PLUS:                  k = KEY_PLUS;
         CH_MINUS:                 k = KEY_MINUS;
         default:                  k = KEY_TEXT;
      endcase
      return k;
   endfunction

endpackage

// File: design/byte_command_motor_pulse_decoder.sv
// Serial byte command decoder for a two-track motor drive.
// Request channel: one received byte per item (req_valid / req_stall).
// Response channel: exactly one result item per byte (rsp_valid / rsp_stall):
// motor write strobe with both clamped pulse widths, reply code, disarmed
// flag and the current drive power.
// CSR channel: csr_valid / csr_ready (always ready), csr_index selects one of
// eight settings; write it only while no byte is in flight.
// Each accepted byte is registered; its result is loaded into the output
// register from the RESULT state once that register is free. CR or LF first
// runs the line scanner over a non-empty line, reading one byte per cycle
// from the line store. One byte is in flight at a time; req_stall stays high
// from acceptance until the result is loaded into the output register.
// A result held by rsp_stall stays in the output register; a finished
// result waits until that register frees up.
// Reset: settings return to their defaults, power to the start value, the
// motors disarmed and the line empty. Line store contents are not cleared.
module byte_command_motor_pulse_decoder #(
   parameter int LINE_MAX = bcmpd_pkg::LINE_MAX_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_motor_write,
   output logic [11:0] rsp_left_pulse_us,
   output logic [11:0] rsp_right_pulse_us,
   output logic [3:0]  rsp_reply_code,
   output logic        rsp_not_armed_flag,
   output logic [9:0]  rsp_drive_power,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [11:0] csr_data
);

   localparam int IW = $clog2(LINE_MAX);
   localparam int LW = $clog2(LINE_MAX + 1);

   bcmpd_pkg::ctrl_state_type state_ff, state_in;
   bcmpd_pkg::cfg_type        cfg_ff;
   logic [9:0]    power_ff, power_in;
   logic          armed_ff, armed_in;
   logic [LW-1:0] len_ff, len_in;
   logic [7:0]    byte_ff;

   logic        out_valid_ff, out_valid_in;
   logic        out_mw_ff, out_mw_in;
   logic [11:0] out_left_ff, out_left_in;
   logic [11:0] out_right_ff, out_right_in;
   logic [3:0]  out_reply_ff, out_reply_in;
   logic        out_flag_ff, out_flag_in;
   logic [9:0]  out_power_ff;

   logic                     accept;
   logic                     out_free;
   logic                     load;
   logic                     scan_start;
   logic                     scan_busy;
   bcmpd_pkg::match_type     match;
   bcmpd_pkg::key_type       key;
   bcmpd_pkg::drive_cmd_type cmd;
   logic [11:0]              left_pulse;
   logic [11:0]              right_pulse;
   logic                     wr_en;
   logic [10:0]              power_sum;
   logic signed [10:0]       power_diff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stop_pulse_us <= bcmpd_pkg::STOP_PULSE_RESET;
         cfg_ff.pulse_max_us  <= bcmpd_pkg::PULSE_MAX_RESET;
         cfg_ff.pulse_min_us  <= bcmpd_pkg::PULSE_MIN_RESET;
         cfg_ff.power_step    <= bcmpd_pkg::POWER_STEP_RESET;
         cfg_ff.power_min     <= bcmpd_pkg::POWER_MIN_RESET;
         cfg_ff.power_max     <= bcmpd_pkg::POWER_MAX_RESET;
         cfg_ff.invert_left   <= 1'b0;
         cfg_ff.invert_right  <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bcmpd_pkg::CSR_STOP_PULSE:   cfg_ff.stop_pulse_us <= csr_data;
            bcmpd_pkg::CSR_PULSE_MAX:    cfg_ff.pulse_max_us  <= csr_data;
            bcmpd_pkg::CSR_PULSE_MIN:    cfg_ff.pulse_min_us  <= csr_data;
            bcmpd_pkg::CSR_POWER_STEP:   cfg_ff.power_step    <= csr_data[7:0];
            bcmpd_pkg::CSR_POWER_MIN:    cfg_ff.power_min     <= csr_data[9:0];
            bcmpd_pkg::CSR_POWER_MAX:    cfg_ff.power_max     <= csr_data[9:0];
            bcmpd_pkg::CSR_INVERT_LEFT:  cfg_ff.invert_left   <= csr_data[0];
            bcmpd_pkg::CSR_INVERT_RIGHT: cfg_ff.invert_right  <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   assign out_free = !out_valid_ff || !rsp_stall;
   assign key      = bcmpd_pkg::classify_key(byte_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bcmpd_pkg::CTRL_IDLE: begin
            if (req_valid) begin
               if (bcmpd_pkg::classify_key(req_rx_byte) == bcmpd_pkg::KEY_LINE_END) begin
                  state_in = bcmpd_pkg::CTRL_SCAN;
               end else begin
                  state_in = bcmpd_pkg::CTRL_RESULT;
               end
            end
         end
         bcmpd_pkg::CTRL_SCAN: begin
            if (!scan_busy) begin
               state_in = bcmpd_pkg::CTRL_RESULT;
            end
         end
         bcmpd_pkg::CTRL_RESULT: begin
            if (out_free) begin
               state_in = bcmpd_pkg::CTRL_IDLE;
            end
         end
         default: state_in = bcmpd_pkg::CTRL_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall  = (state_ff != bcmpd_pkg::CTRL_IDLE);
      accept     = (state_ff == bcmpd_pkg::CTRL_IDLE) && req_valid;
      scan_start = accept &&
                   (bcmpd_pkg::classify_key(req_rx_byte) == bcmpd_pkg::KEY_LINE_END);
      load       = (state_ff == bcmpd_pkg::CTRL_RESULT) && out_free;
   end

   assign power_sum  = {1'b0, power_ff} + {3'b000, cfg_ff.power_step};
   assign power_diff = $signed({1'b0, power_ff}) - $signed({3'b000, cfg_ff.power_step});

   // result of the held byte
   always_comb begin
      out_mw_in    = 1'b0;
      out_reply_in = bcmpd_pkg::REPLY_NONE;
      out_flag_in  = 1'b0;
      cmd          = '0;
      power_in     = power_ff;
      armed_in     = armed_ff;
      len_in       = '0;
      wr_en        = 1'b0;
      unique case (key)
         bcmpd_pkg::KEY_LINE_END: begin
            unique case (match)
               bcmpd_pkg::MATCH_MON: begin
                  out_mw_in    = 1'b1;
                  armed_in     = 1'b1;
                  out_reply_in = bcmpd_pkg::REPLY_ON;
               end
               bcmpd_pkg::MATCH_MOFF: begin
                  out_mw_in    = 1'b1;
                  armed_in     = 1'b0;
                  out_reply_in = bcmpd_pkg::REPLY_OFF;
               end
               bcmpd_pkg::MATCH_HELP:    out_reply_in = bcmpd_pkg::REPLY_HELP;
               bcmpd_pkg::MATCH_UNKNOWN: out_reply_in = bcmpd_pkg::REPLY_UNKNOWN;
               default:                  out_reply_in = bcmpd_pkg::REPLY_NONE;
            endcase
         end
         bcmpd_pkg::KEY_FWD, bcmpd_pkg::KEY_REV,
         bcmpd_pkg::KEY_LEFT, bcmpd_pkg::KEY_RIGHT: begin
            out_mw_in   = 1'b1;
            out_flag_in = !armed_ff;
            cmd.active  = armed_ff;
            unique case (key)
               bcmpd_pkg::KEY_FWD: begin
                  out_reply_in = bcmpd_pkg::REPLY_FWD;
               end
               bcmpd_pkg::KEY_REV: begin
                  out_reply_in  = bcmpd_pkg::REPLY_REV;
                  cmd.left_neg  = 1'b1;
                  cmd.right_neg = 1'b1;
               end
               bcmpd_pkg::KEY_LEFT: begin
                  out_reply_in = bcmpd_pkg::REPLY_LEFT;
                  cmd.left_neg = 1'b1;
               end
               default: begin
                  out_reply_in  = bcmpd_pkg::REPLY_RIGHT;
                  cmd.right_neg = 1'b1;
               end
            endcase
         end
         bcmpd_pkg::KEY_STOP: begin
            out_mw_in    = 1'b1;
            out_reply_in = bcmpd_pkg::REPLY_STOP;
         end
         bcmpd_pkg::KEY_PLUS: begin
            out_reply_in = bcmpd_pkg::REPLY_SPEED;
            power_in     = (power_sum > {1'b0, cfg_ff.power_max}) ?
                           cfg_ff.power_max : power_sum[9:0];
         end
         bcmpd_pkg::KEY_MINUS: begin
            out_reply_in = bcmpd_pkg::REPLY_SPEED;
            power_in     = (power_diff < $signed({1'b0, cfg_ff.power_min})) ?
                           cfg_ff.power_min : power_diff[9:0];
         end
         default: begin
            // drop the byte and empty the line when the store is full
            if (len_ff < LW'(LINE_MAX)) begin
               wr_en  = 1'b1;
               len_in = len_ff + LW'(1);
            end
         end
      endcase
      out_left_in  = out_mw_in ? left_pulse : '0;
      out_right_in = out_mw_in ? right_pulse : '0;
      out_valid_in = load || (out_valid_ff && rsp_stall);
   end

   bcmpd_pulse u_pulse (
      .cfg            (cfg_ff),
      .cmd            (cmd),
      .power          (power_ff),
      .left_pulse_us  (left_pulse),
      .right_pulse_us (right_pulse)
   );

   bcmpd_line_scan #(
      .LINE_MAX (LINE_MAX)
   ) u_line_scan (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (load && wr_en),
      .wr_addr  (len_ff[IW-1:0]),
      .wr_data  (byte_ff),
      .start    (scan_start),
      .line_len (len_ff),
      .busy     (scan_busy),
      .match    (match)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bcmpd_pkg::CTRL_IDLE;
         power_ff     <= bcmpd_pkg::START_POWER;
         armed_ff     <= 1'b0;
         len_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         if (load) begin
            power_ff <= power_in;
            armed_ff <= armed_in;
            len_ff   <= len_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_rx_byte;
      end
      if (load) begin
         out_mw_ff    <= out_mw_in;
         out_left_ff  <= out_left_in;
         out_right_ff <= out_right_in;
         out_reply_ff <= out_reply_in;
         out_flag_ff  <= out_flag_in;
         out_power_ff <= power_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_motor_write    = out_mw_ff;
   assign rsp_left_pulse_us  = out_left_ff;
   assign rsp_right_pulse_us = out_right_ff;
   assign rsp_reply_code     = out_reply_ff;
   assign rsp_not_armed_flag = out_flag_ff;
   assign rsp_drive_power    = out_power_ff;

endmodule

// File: design/bcmpd_pulse.sv
module bcmpd_pulse (
   input  bcmpd_pkg::cfg_type       cfg,
   input  bcmpd_pkg::drive_cmd_type cmd,
   input  logic [9:0]               power,
   output logic [11:0]              left_pulse_us,
   output logic [11:0]              right_pulse_us
);

   // stop +/- power, then clamp: max test first, then min
   function automatic logic [11:0] side_pulse(input bcmpd_pkg::cfg_type c,
                                              input logic active,
                                              input logic neg,
                                              input logic [9:0] pwr);
      logic signed [13:0] stop_s;
      logic signed [13:0] pwr_s;
      logic signed [13:0] raw;
      stop_s = $signed({2'b00, c.stop_pulse_us});
      pwr_s  = $signed({4'b0000, pwr});
      if (!active) begin
         raw = stop_s;
      end else if (neg) begin
         raw = stop_s - pwr_s;
      end else begin
         raw = stop_s + pwr_s;
      end
      if (raw > $signed({2'b00, c.pulse_max_us})) begin
         return c.pulse_max_us;
      end
      if (raw < $signed({2'b00, c.pulse_min_us})) begin
         return c.pulse_min_us;
      end
      return raw[11:0];
   endfunction

   assign left_pulse_us  = side_pulse(cfg, cmd.active, cmd.left_neg ^ cfg.invert_left, power);
   assign right_pulse_us = side_pulse(cfg, cmd.active, cmd.right_neg ^ cfg.invert_right, power);

endmodule

// File: design/bcmpd_line_scan.sv
module bcmpd_line_scan #(
   parameter int LINE_MAX = bcmpd_pkg::LINE_MAX_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [$clog2(LINE_MAX)-1:0]  wr_addr,
   input  logic [7:0]                   wr_data,
   input  logic                         start,
   input  logic [$clog2(LINE_MAX+1)-1:0] line_len,
   output logic                         busy,
   output bcmpd_pkg::match_type         match
);

   localparam int IW = $clog2(LINE_MAX);
   localparam int LW = $clog2(LINE_MAX + 1);

   logic [7:0] mem [LINE_MAX];
   logic [7:0] rd_data_ff;
   logic [IW-1:0] rd_addr;

   bcmpd_pkg::scan_state_type state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [LW-1:0] len_ff, len_in;
   logic          found_ff, found_in;
   logic [IW-1:0] s_ff, s_in;
   logic [IW-1:0] e_ff, e_in;
   logic [7:0]    win_ff [4];

   logic [LW-1:0] idx_next;
   logic          last;
   logic          trim;
   logic [IW-1:0] s_cur;
   logic [IW-1:0] offset;
   logic          win_we;
   logic [LW-1:0] tlen;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign idx_next = LW'(idx_ff) + LW'(1);
   assign last     = (idx_next == len_ff);
   assign trim     = bcmpd_pkg::is_trim(rd_data_ff);
   assign s_cur    = found_ff ? s_ff : idx_ff;
   assign offset   = idx_ff - s_cur;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bcmpd_pkg::SCAN_IDLE: begin
            if (start && (line_len != '0)) begin
               state_in = bcmpd_pkg::SCAN_RUN;
            end
         end
         bcmpd_pkg::SCAN_RUN: begin
            if (last) begin
               state_in = bcmpd_pkg::SCAN_IDLE;
            end
         end
         default: state_in = bcmpd_pkg::SCAN_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      busy     = (state_ff == bcmpd_pkg::SCAN_RUN);
      rd_addr  = '0;
      idx_in   = idx_ff;
      len_in   = len_ff;
      found_in = found_ff;
      s_in     = s_ff;
      e_in     = e_ff;
      win_we   = 1'b0;
      unique case (state_ff)
         bcmpd_pkg::SCAN_IDLE: begin
            if (start) begin
               idx_in   = '0;
               len_in   = line_len;
               found_in = 1'b0;
            end
         end
         bcmpd_pkg::SCAN_RUN: begin
            rd_addr = last ? '0 : idx_next[IW-1:0];
            idx_in  = idx_next[IW-1:0];
            // keep the first four bytes of the trimmed line
            win_we  = (found_ff || !trim) && ((offset >> 2) == '0);
            if (!trim) begin
               found_in = 1'b1;
               s_in     = s_cur;
               e_in     = idx_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bcmpd_pkg::SCAN_IDLE;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      len_ff <= len_in;
      s_ff   <= s_in;
      e_ff   <= e_in;
      if (win_we) begin
         win_ff[offset[1:0]] <= bcmpd_pkg::to_lower(rd_data_ff);
      end
   end

   assign tlen = LW'(e_ff) - LW'(s_ff) + LW'(1);

   always_comb begin
      if (!found_ff) begin
         match = bcmpd_pkg::MATCH_EMPTY;
      end else if ((tlen == LW'(3)) && (win_ff[0] == bcmpd_pkg::CH_M) &&
                   (win_ff[1] == bcmpd_pkg::CH_O) && (win_ff[2] == bcmpd_pkg::CH_N)) begin
         match = bcmpd_pkg::MATCH_MON;
      end else if ((tlen == LW'(4)) && (win_ff[0] == bcmpd_pkg::CH_M) &&
                   (win_ff[1] == bcmpd_pkg::CH_O) && (win_ff[2] == bcmpd_pkg::CH_F) &&
                   (win_ff[3] == bcmpd_pkg::CH_F)) begin
         match = bcmpd_pkg::MATCH_MOFF;
      end else if (((tlen == LW'(4)) && (win_ff[0] == bcmpd_pkg::CH_H) &&
                    (win_ff[1] == bcmpd_pkg::CH_E) && (win_ff[2] == bcmpd_pkg::CH_L) &&
                    (win_ff[3] == bcmpd_pkg::CH_P)) ||
                   ((tlen == LW'(1)) && (win_ff[0] == bcmpd_pkg::CH_QUEST))) begin
         match = bcmpd_pkg::MATCH_HELP;
      end else begin
         match = bcmpd_pkg::MATCH_UNKNOWN;
      end
   end

endmodule
